// ===== rtl/core/wfc_pkg.sv =====
package wfc_pkg;

   localparam int CELLS_DEF      = 1024;
   localparam int PATTERNS_DEF   = 32;
   localparam int DIRECTIONS_DEF = 6;
   localparam int CNT_W          = 6;
   localparam int CO_W           = 11;

   localparam logic [2:0] REQ_RULE     = 3'd0;
   localparam logic [2:0] REQ_RESET    = 3'd1;
   localparam logic [2:0] REQ_BAN      = 3'd2;
   localparam logic [2:0] REQ_COLLAPSE = 3'd3;
   localparam logic [2:0] REQ_PROP     = 3'd4;

   localparam logic [2:0] REG_WIDTH    = 3'd0;
   localparam logic [2:0] REG_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_DEPTH    = 3'd2;
   localparam logic [2:0] REG_PERIODIC = 3'd3;
   localparam logic [2:0] REG_WINDOW   = 3'd4;
   localparam logic [2:0] REG_NDIR     = 3'd5;
   localparam logic [2:0] REG_NPAT     = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_CONTRA = 2'd1;
   localparam logic [1:0] ST_TOOBIG = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  cell_req;
      logic [4:0]  pattern;
      logic [2:0]  direction;
      logic [31:0] rule_mask;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] allowed_mask;
      logic [5:0]  remaining;
      logic        cell_zero_alive;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]      allowed;
      logic [CNT_W-1:0] remaining;
   } cell_entry_type;

   function automatic logic [5:0] popcount32(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int b = 0; b < 32; b++) n = n + 6'(v[b]);
      return n;
   endfunction

   function automatic logic [4:0] lowest_bit(input logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int b = 31; b >= 0; b--) if (v[b]) r = 5'(b);
      return r;
   endfunction

endpackage

// ===== rtl/core/wfc_constraint_propagator_top.sv =====
// Order: rule loads and out-of-grid requests pass S_SZ1, S_SZ2, S_DISP and the result reads;
// ban/collapse adds a row walk subtracting the width per row, then bans each pattern in turn.
// Reset wave: per pattern, reads the rule row of each direction, then fills the counter store.
// Propagate: per popped ban and direction, reads the neighbour, then updates each supported pattern.
// One word at a time; busy stays high until the result strobe. Receiver cannot stall.
// Reset is synchronous; afterwards a sweep over all CELLS entries sets the cell store before start is taken.
module wfc_constraint_propagator_top #(
   parameter int CELLS      = wfc_pkg::CELLS_DEF,
   parameter int PATTERNS   = wfc_pkg::PATTERNS_DEF,
   parameter int DIRECTIONS = wfc_pkg::DIRECTIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wfc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output wfc_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int CW     = wfc_pkg::CNT_W;
   localparam int OW     = wfc_pkg::CO_W;
   localparam int CAW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW     = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
   localparam int DW     = $clog2(DIRECTIONS);
   localparam int RW     = DIRECTIONS * CW;
   localparam int SDEPTH = CELLS * PATTERNS;
   localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int EW     = 3 * OW + PW;
   localparam int PLIM   = (PATTERNS < 32) ? PATTERNS : 32;
   localparam int DLIM   = (DIRECTIONS < 6) ? DIRECTIONS : 6;

   typedef enum logic [23:0] {
      S_CLR  = 24'h000001, S_IDLE = 24'h000002, S_SZ1  = 24'h000004, S_SZ2  = 24'h000008,
      S_DISP = 24'h000010, W_RRD  = 24'h000020, W_RCAP = 24'h000040, W_FILL = 24'h000080,
      B_DEC  = 24'h000100, B_RD   = 24'h000200, B_LD   = 24'h000400, B_T    = 24'h000800,
      P_POP  = 24'h001000, P_ENT  = 24'h002000, P_DIR  = 24'h004000, P_M1   = 24'h008000,
      P_M2   = 24'h010000, P_RD   = 24'h020000, P_LD   = 24'h040000, P_T    = 24'h080000,
      P_CNT  = 24'h100000, F_R0   = 24'h200000, F_R1   = 24'h400000, F_R2   = 24'h800000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] cfg_w_ff, cfg_h_ff, cfg_d_ff;
   logic        cfg_per_ff;
   logic [3:0]  cfg_win_ff;
   logic [2:0]  cfg_dir_ff;
   logic [5:0]  cfg_pat_ff;

   wfc_pkg::req_word_type req_ff, req_in;
   logic [CAW:0]    c_ff, c_in;
   logic [21:0]     wh_ff, wh_in;
   logic [32:0]     n_ff, n_in;
   logic            tb_ff, tb_in;
   logic [PW:0]     j_ff, j_in;
   logic [2:0]      k_ff, k_in;
   logic [RW-1:0]   rowvec_ff, rowvec_in;
   logic [OW-1:0]   nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [OW-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [PW-1:0]   p1_ff, p1_in;
   logic [2:0]      i_ff, i_in;
   logic [22:0]     t1_ff, t1_in;
   logic [34:0]     flat_ff, flat_in;
   logic [31:0]     allowed_ff, allowed_in, pend_ff, pend_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [4:0]      t_ff, t_in;
   logic [SAW:0]    sp_ff, sp_in;
   logic            contra_ff, contra_in, alive_ff, alive_in;
   logic            rsp_valid_ff, rsp_valid_in;
   wfc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [10:0] dw, dh, dd;
   logic [3:0]  dn;
   logic [5:0]  p_eff;
   logic [2:0]  d_eff;
   logic [31:0] pmask;

   logic                   rule_we;
   logic [DW+PW-1:0]       rule_waddr, rule_raddr;
   logic [31:0]            rule_rd;
   logic                   cell_we;
   logic [CAW-1:0]         cell_waddr, cell_raddr;
   wfc_pkg::cell_entry_type cell_wd, cell_rd;
   logic                   cnt_we;
   logic [CAW+PW-1:0]      cnt_waddr, cnt_raddr;
   logic [RW-1:0]          cnt_wd, cnt_rd;
   logic                   stk_we;
   logic [SAW-1:0]         stk_waddr, stk_raddr;
   logic [EW-1:0]          stk_wd, stk_rd;

   logic              ban_go;
   logic [4:0]        tsel;
   logic [CW-1:0]     cur_cnt;
   logic [2:0]        opp_k;
   logic signed [12:0] sx, sy, sz, x2, y2, z2, xw, yw, zw;
   logic              skip;

   assign dw = (cfg_w_ff == '0) ? 11'd1 : cfg_w_ff;
   assign dh = (cfg_h_ff == '0) ? 11'd1 : cfg_h_ff;
   assign dd = (cfg_d_ff == '0) ? 11'd1 : cfg_d_ff;
   assign dn = (cfg_win_ff == '0) ? 4'd1 : cfg_win_ff;
   assign p_eff = (cfg_pat_ff == '0) ? 6'd1 :
                  (32'(cfg_pat_ff) > PLIM) ? 6'(PLIM) : cfg_pat_ff;
   assign d_eff = (cfg_dir_ff < 3'd4) ? 3'd4 :
                  (32'(cfg_dir_ff) > DLIM) ? 3'(DLIM) : cfg_dir_ff;
   assign pmask = (p_eff >= 6'd32) ? '1 : ((32'd1 << p_eff) - 32'd1);

   assign pready = 1'b1;
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   always_comb begin
      case (paddr[4:2])
         wfc_pkg::REG_WIDTH:    prdata = 32'(cfg_w_ff);
         wfc_pkg::REG_HEIGHT:   prdata = 32'(cfg_h_ff);
         wfc_pkg::REG_DEPTH:    prdata = 32'(cfg_d_ff);
         wfc_pkg::REG_PERIODIC: prdata = 32'(cfg_per_ff);
         wfc_pkg::REG_WINDOW:   prdata = 32'(cfg_win_ff);
         wfc_pkg::REG_NDIR:     prdata = 32'(cfg_dir_ff);
         wfc_pkg::REG_NPAT:     prdata = 32'(cfg_pat_ff);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff   <= 11'd32;
         cfg_h_ff   <= 11'd32;
         cfg_d_ff   <= 11'd1;
         cfg_per_ff <= 1'b0;
         cfg_win_ff <= 4'd1;
         cfg_dir_ff <= 3'd4;
         cfg_pat_ff <= 6'd32;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            wfc_pkg::REG_WIDTH:    cfg_w_ff   <= pwdata[10:0];
            wfc_pkg::REG_HEIGHT:   cfg_h_ff   <= pwdata[10:0];
            wfc_pkg::REG_DEPTH:    cfg_d_ff   <= pwdata[10:0];
            wfc_pkg::REG_PERIODIC: cfg_per_ff <= pwdata[0];
            wfc_pkg::REG_WINDOW:   cfg_win_ff <= pwdata[3:0];
            wfc_pkg::REG_NDIR:     cfg_dir_ff <= pwdata[2:0];
            wfc_pkg::REG_NPAT:     cfg_pat_ff <= pwdata[5:0];
            default: begin
            end
         endcase
      end
   end

   // neighbour step
   always_comb begin
      case (i_ff)
         3'd0:    begin sx = 13'sd1;  sy = 13'sd0;  sz = 13'sd0;  end
         3'd1:    begin sx = 13'sd0;  sy = 13'sd1;  sz = 13'sd0;  end
         3'd2:    begin sx = -13'sd1; sy = 13'sd0;  sz = 13'sd0;  end
         3'd3:    begin sx = 13'sd0;  sy = -13'sd1; sz = 13'sd0;  end
         3'd4:    begin sx = 13'sd0;  sy = 13'sd0;  sz = 13'sd1;  end
         3'd5:    begin sx = 13'sd0;  sy = 13'sd0;  sz = -13'sd1; end
         default: begin sx = 13'sd0;  sy = 13'sd0;  sz = 13'sd0;  end
      endcase
      x2 = $signed({2'b00, px_ff}) + sx;
      y2 = $signed({2'b00, py_ff}) + sy;
      z2 = $signed({2'b00, pz_ff}) + sz;
      skip = !cfg_per_ff && (x2 < 0 || y2 < 0 || z2 < 0 ||
             x2 + $signed({9'd0, dn}) > $signed({2'b00, dw}) ||
             y2 + $signed({9'd0, dn}) > $signed({2'b00, dh}) ||
             z2 + 13'sd1 > $signed({2'b00, dd}));
      xw = (x2 < 0) ? $signed({2'b00, dw}) - 13'sd1 :
           (x2 >= $signed({2'b00, dw})) ? x2 - $signed({2'b00, dw}) : x2;
      yw = (y2 < 0) ? $signed({2'b00, dh}) - 13'sd1 :
           (y2 >= $signed({2'b00, dh})) ? y2 - $signed({2'b00, dh}) : y2;
      zw = (z2 < 0) ? $signed({2'b00, dd}) - 13'sd1 :
           (z2 >= $signed({2'b00, dd})) ? z2 - $signed({2'b00, dd}) : z2;
   end

   assign opp_k = (k_ff < 3'd4) ? (k_ff ^ 3'd2) : (k_ff ^ 3'd1);
   assign cur_cnt = cnt_rd[i_ff*CW +: CW];

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      c_in = c_ff;
      wh_in = wh_ff;
      n_in = n_ff;
      tb_in = tb_ff;
      j_in = j_ff;
      k_in = k_ff;
      rowvec_in = rowvec_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      p1_in = p1_ff;
      i_in = i_ff;
      t1_in = t1_ff;
      flat_in = flat_ff;
      allowed_in = allowed_ff;
      pend_in = pend_ff;
      rem_in = rem_ff;
      t_in = t_ff;
      sp_in = sp_ff;
      contra_in = contra_ff;
      alive_in = alive_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in = rsp_word_ff;
      rule_we = 1'b0;
      rule_waddr = {req_ff.direction[DW-1:0], PW'(req_ff.pattern)};
      rule_raddr = {DW'(opp_k), j_ff[PW-1:0]};
      cell_we = 1'b0;
      cell_waddr = flat_ff[CAW-1:0];
      cell_wd = '{allowed: allowed_ff, remaining: rem_ff};
      cell_raddr = flat_ff[CAW-1:0];
      cnt_we = 1'b0;
      cnt_waddr = {flat_ff[CAW-1:0], PW'(t_ff)};
      cnt_wd = cnt_rd;
      cnt_raddr = {flat_ff[CAW-1:0], PW'(wfc_pkg::lowest_bit(pend_ff))};
      stk_we = 1'b0;
      stk_waddr = sp_ff[SAW-1:0];
      stk_wd = '0;
      stk_raddr = SAW'(sp_ff - 1'b1);
      ban_go = 1'b0;
      tsel = t_ff;

      case (state_ff)
         S_CLR: begin
            cell_we = 1'b1;
            cell_waddr = c_ff[CAW-1:0];
            cell_wd = '{allowed: '1, remaining: '0};
            c_in = c_ff + 1'b1;
            if (c_ff == (CAW+1)'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_word;
               state_in = S_SZ1;
            end
         end
         S_SZ1: begin
            wh_in = 22'(dw) * 22'(dh);
            state_in = S_SZ2;
         end
         S_SZ2: begin
            n_in = 33'(wh_ff) * 33'(dd);
            state_in = S_DISP;
         end
         S_DISP: begin
            tb_in = (n_ff > 33'(CELLS));
            flat_in = 35'(req_ff.cell_req);
            state_in = F_R0;
            if (req_ff.req_type == wfc_pkg::REQ_RULE) begin
               rule_we = (32'(req_ff.direction) < DIRECTIONS) &&
                         (32'(req_ff.pattern) < PATTERNS);
            end else if (n_ff <= 33'(CELLS)) begin
               case (req_ff.req_type)
                  wfc_pkg::REQ_RESET: begin
                     j_in = '0;
                     k_in = '0;
                     state_in = W_RRD;
                  end
                  wfc_pkg::REQ_BAN, wfc_pkg::REQ_COLLAPSE: begin
                     if (33'(req_ff.cell_req) < n_ff) begin
                        nx_in = OW'(req_ff.cell_req);
                        ny_in = '0;
                        nz_in = '0;
                        state_in = B_DEC;
                     end
                  end
                  wfc_pkg::REQ_PROP: state_in = P_POP;
                  default: state_in = F_R0;
               endcase
            end
         end
         W_RRD: state_in = W_RCAP;
         W_RCAP: begin
            rowvec_in[k_ff*CW +: CW] = (32'(j_ff) < 32'(p_eff) && k_ff < d_eff) ?
                                       wfc_pkg::popcount32(rule_rd & pmask) : '0;
            if (32'(k_ff) == DIRECTIONS - 1) begin
               c_in = '0;
               state_in = W_FILL;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = W_RRD;
            end
         end
         W_FILL: begin
            cnt_we = 1'b1;
            cnt_waddr = {c_ff[CAW-1:0], j_ff[PW-1:0]};
            cnt_wd = rowvec_ff;
            if (j_ff == '0) begin
               cell_we = 1'b1;
               cell_waddr = c_ff[CAW-1:0];
               cell_wd = '{allowed: pmask, remaining: p_eff};
            end
            c_in = c_ff + 1'b1;
            if (c_ff == (CAW+1)'(CELLS - 1)) begin
               k_in = '0;
               if (32'(j_ff) == PATTERNS - 1) begin
                  sp_in = '0;
                  contra_in = 1'b0;
                  state_in = F_R0;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = W_RRD;
               end
            end
         end
         B_DEC: begin
            if ({1'b0, nx_ff} >= dw) begin
               nx_in = nx_ff - dw;
               if (ny_ff == dh - 11'd1) begin
                  ny_in = '0;
                  nz_in = nz_ff + 1'b1;
               end else begin
                  ny_in = ny_ff + 1'b1;
               end
            end else begin
               state_in = B_RD;
            end
         end
         B_RD: state_in = B_LD;
         B_LD: begin
            allowed_in = cell_rd.allowed;
            rem_in = cell_rd.remaining;
            if (req_ff.req_type == wfc_pkg::REQ_BAN)
               pend_in = (6'(req_ff.pattern) < p_eff) ?
                         (cell_rd.allowed & (32'd1 << req_ff.pattern)) : '0;
            else
               pend_in = cell_rd.allowed & pmask & ~(32'd1 << req_ff.pattern);
            state_in = B_T;
         end
         B_T: begin
            if (pend_ff == '0) begin
               cell_we = 1'b1;
               state_in = F_R0;
            end else begin
               tsel = wfc_pkg::lowest_bit(pend_ff);
               pend_in = pend_ff & ~(32'd1 << tsel);
               ban_go = 1'b1;
            end
         end
         P_POP: begin
            if (sp_ff == '0) begin
               state_in = F_R0;
            end else begin
               sp_in = sp_ff - 1'b1;
               state_in = P_ENT;
            end
         end
         P_ENT: begin
            {px_in, py_in, pz_in, p1_in} = stk_rd;
            i_in = '0;
            state_in = (32'(stk_rd[PW-1:0]) >= PATTERNS) ? P_POP : P_DIR;
         end
         P_DIR: begin
            if (i_ff >= d_eff) begin
               state_in = P_POP;
            end else if (skip) begin
               i_in = i_ff + 1'b1;
            end else begin
               nx_in = xw[OW-1:0];
               ny_in = yw[OW-1:0];
               nz_in = zw[OW-1:0];
               state_in = P_M1;
            end
         end
         P_M1: begin
            t1_in = 23'(dh) * 23'(nz_ff) + 23'(ny_ff);
            state_in = P_M2;
         end
         P_M2: begin
            flat_in = 35'(dw) * 35'(t1_ff) + 35'(nx_ff);
            state_in = P_RD;
         end
         P_RD: begin
            rule_raddr = {i_ff[DW-1:0], p1_ff};
            if (flat_ff >= 35'(CELLS)) begin
               i_in = i_ff + 1'b1;
               state_in = P_DIR;
            end else begin
               state_in = P_LD;
            end
         end
         P_LD: begin
            allowed_in = cell_rd.allowed;
            rem_in = cell_rd.remaining;
            pend_in = rule_rd & pmask & cell_rd.allowed;
            state_in = P_T;
         end
         P_T: begin
            if (pend_ff == '0) begin
               cell_we = 1'b1;
               i_in = i_ff + 1'b1;
               state_in = P_DIR;
            end else begin
               t_in = wfc_pkg::lowest_bit(pend_ff);
               state_in = P_CNT;
            end
         end
         P_CNT: begin
            pend_in = pend_ff & ~(32'd1 << t_ff);
            if (cur_cnt != '0) begin
               if (cur_cnt == CW'(1)) begin
                  ban_go = 1'b1;
               end else begin
                  cnt_we = 1'b1;
                  cnt_wd[i_ff*CW +: CW] = cur_cnt - 1'b1;
               end
            end
            state_in = P_T;
         end
         F_R0: begin
            cell_raddr = '0;
            state_in = F_R1;
         end
         F_R1: begin
            alive_in = (cell_rd.remaining != '0);
            cell_raddr = CAW'(req_ff.cell_req);
            state_in = F_R2;
         end
         F_R2: begin
            rsp_valid_in = 1'b1;
            rsp_word_in.status = tb_ff ? wfc_pkg::ST_TOOBIG :
                                 contra_ff ? wfc_pkg::ST_CONTRA : wfc_pkg::ST_OK;
            if (32'(req_ff.cell_req) < CELLS) begin
               rsp_word_in.allowed_mask = cell_rd.allowed;
               rsp_word_in.remaining = cell_rd.remaining;
            end else begin
               rsp_word_in.allowed_mask = '0;
               rsp_word_in.remaining = '0;
            end
            rsp_word_in.cell_zero_alive = alive_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (ban_go) begin
         cnt_we = 1'b1;
         cnt_waddr = {flat_ff[CAW-1:0], PW'(tsel)};
         cnt_wd = '0;
         allowed_in = allowed_ff & ~(32'd1 << tsel);
         if (32'(sp_ff) < SDEPTH) begin
            stk_we = 1'b1;
            stk_wd = {nx_ff, ny_ff, nz_ff, PW'(tsel)};
            sp_in = sp_ff + 1'b1;
         end
         rem_in = (rem_ff != '0) ? rem_ff - 1'b1 : '0;
         if (rem_in == '0) contra_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         c_ff         <= '0;
         sp_ff        <= '0;
         contra_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         c_ff         <= c_in;
         sp_ff        <= sp_in;
         contra_ff    <= contra_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      wh_ff       <= wh_in;
      n_ff        <= n_in;
      tb_ff       <= tb_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rowvec_ff   <= rowvec_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nz_ff       <= nz_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      p1_ff       <= p1_in;
      i_ff        <= i_in;
      t1_ff       <= t1_in;
      flat_ff     <= flat_in;
      allowed_ff  <= allowed_in;
      pend_ff     <= pend_in;
      rem_ff      <= rem_in;
      t_ff        <= t_in;
      alive_ff    <= alive_in;
      rsp_word_ff <= rsp_word_in;
   end

   wfc_ram #(.WIDTH(32), .ADDR_W(DW + PW), .DEPTH(DIRECTIONS << PW)) u_rule_ram (
      .clock(clock), .wr_en(rule_we), .wr_addr(rule_waddr), .wr_data(req_ff.rule_mask),
      .rd_addr(rule_raddr), .rd_data(rule_rd)
   );

   wfc_ram #(.WIDTH(32 + CW), .ADDR_W(CAW), .DEPTH(CELLS)) u_cell_ram (
      .clock(clock), .wr_en(cell_we), .wr_addr(cell_waddr), .wr_data(cell_wd),
      .rd_addr(cell_raddr), .rd_data(cell_rd)
   );

   wfc_ram #(.WIDTH(RW), .ADDR_W(CAW + PW), .DEPTH(CELLS << PW)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wd),
      .rd_addr(cnt_raddr), .rd_data(cnt_rd)
   );

   wfc_ram #(.WIDTH(EW), .ADDR_W(SAW), .DEPTH(SDEPTH)) u_stk_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wd),
      .rd_addr(stk_raddr), .rd_data(stk_rd)
   );

endmodule

// ===== rtl/core/wfc_ram.sv =====
module wfc_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10,
   parameter int DEPTH  = 1024
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/wfc_checker.sv =====
module wfc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input wfc_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input wfc_pkg::rsp_word_type rsp_word,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [4:0]            paddr,
   input logic [31:0]           pwdata,
   input logic [31:0]           prdata,
   input logic                  pready
);

   a_reset_busy: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("not busy after reset");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted word did not raise busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != 2'd3)
      else $error("bad status code");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind wfc_constraint_propagator_top wfc_checker u_wfc_checker (.*);
